>>> hw/rtl/rc_frame_receiver_decoder_assert.svh
// ----------------------------------------------------------------------------
// Remote control frame decoder assertion macros
// Shared property forms for the checker of the frame decoder.
// ----------------------------------------------------------------------------
`ifndef RC_FRAME_RECEIVER_DECODER_ASSERT_SVH
`define RC_FRAME_RECEIVER_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while the reset is low.
`define RCFRD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rcfrd assertion failed");

// Next-cycle implication, disabled while the reset is low.
`define RCFRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rcfrd assertion failed");

`endif

>>> hw/rtl/rcfrd_pkg.sv
// ----------------------------------------------------------------------------
// Remote control frame decoder package
// Types and constants shared by the front end, the queue and the decoder.
// ----------------------------------------------------------------------------
package rcfrd_pkg;

    localparam int FRAME_BYTES = 16;
    localparam int COUNT_W     = 5;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] SW_UP   = 2'd0;
    localparam logic [1:0] SW_MID  = 2'd1;
    localparam logic [1:0] SW_DOWN = 2'd2;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_IDLE = 1'b1;

    typedef logic [FRAME_BYTES-1:0][7:0] t_frame;

    typedef struct packed {
        logic full;
        logic nonempty;
    } t_queue_status;

endpackage

>>> hw/rtl/rcfrd_if.sv
// ----------------------------------------------------------------------------
// Remote control frame decoder channels
// Valid/ready channels for UART events in and decoded frames out.
// ----------------------------------------------------------------------------
interface rcfrd_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

interface rcfrd_out_if;
    logic               valid;
    logic               ready;
    logic signed [10:0] right_horizontal;
    logic signed [10:0] right_vertical;
    logic signed [10:0] left_horizontal;
    logic signed [10:0] left_vertical;
    logic [1:0]         switch_left;
    logic [1:0]         switch_right;
    logic signed [15:0] mouse_x;
    logic signed [15:0] mouse_y;
    logic signed [15:0] mouse_z;
    logic               press_left;
    logic               press_right;
    logic [15:0]        key_mask;

    modport source (
        output valid, input ready,
        output right_horizontal, output right_vertical,
        output left_horizontal, output left_vertical,
        output switch_left, output switch_right,
        output mouse_x, output mouse_y, output mouse_z,
        output press_left, output press_right, output key_mask
    );
    modport sink (
        input valid, output ready,
        input right_horizontal, input right_vertical,
        input left_horizontal, input left_vertical,
        input switch_left, input switch_right,
        input mouse_x, input mouse_y, input mouse_z,
        input press_left, input press_right, input key_mask
    );
endinterface

>>> hw/rtl/rcfrd_front.sv
// ----------------------------------------------------------------------------
// Remote control frame decoder front end
// Takes UART events, keeps the byte window and count, queues complete frames.
// ----------------------------------------------------------------------------
module rcfrd_front #(
    parameter int FRAME_LEN = 18
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    rcfrd_in_if.sink               i_in,
    input  rcfrd_pkg::t_queue_status i_q_status,
    output logic                   o_push,
    output rcfrd_pkg::t_frame      o_frame
);
    import rcfrd_pkg::*;

    logic [7:0]         r_window [FRAME_LEN];
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic               accept;

    assign i_in.ready = !i_q_status.full;
    assign accept     = i_in.valid && i_in.ready;
    assign o_push     = accept && (i_in.cmd == CMD_IDLE)
                        && (r_count >= COUNT_W'(FRAME_LEN));

    always_comb begin
        n_count = r_count;
        if (accept) begin
            if (i_in.cmd == CMD_IDLE) begin
                n_count = '0;
            end else if (r_count != COUNT_MAX) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_in.cmd == CMD_BYTE)) begin
            for (int i = 0; i < FRAME_LEN - 1; i++) begin
                r_window[i] <= r_window[i+1];
            end
            r_window[FRAME_LEN-1] <= i_in.rx_byte;
        end
    end

    always_comb begin
        for (int i = 0; i < FRAME_BYTES; i++) begin
            o_frame[i] = r_window[i];
        end
    end

endmodule

>>> hw/rtl/rcfrd_queue.sv
// ----------------------------------------------------------------------------
// Remote control frame decoder queue
// Short first-in first-out store of frames between the front end and decoder.
// ----------------------------------------------------------------------------
module rcfrd_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  rcfrd_pkg::t_frame        i_frame,
    input  logic                     i_pop,
    output rcfrd_pkg::t_frame        o_frame,
    output rcfrd_pkg::t_queue_status o_status
);
    import rcfrd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_frame           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;

    assign o_status.full     = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_status.nonempty = (r_cnt != '0);
    assign o_frame           = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

endmodule

>>> hw/rtl/rcfrd_back.sv
// ----------------------------------------------------------------------------
// Remote control frame decoder back end
// Unpacks queued frames, tracks held switch positions, drives the result.
// ----------------------------------------------------------------------------
module rcfrd_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  rcfrd_pkg::t_frame        i_frame,
    input  rcfrd_pkg::t_queue_status i_q_status,
    output logic                     o_pop,
    rcfrd_out_if.source              o_out
);
    import rcfrd_pkg::*;

    logic               r_valid;
    logic [1:0]         r_held_left;
    logic [1:0]         r_held_right;
    logic [1:0]         n_held_left;
    logic [1:0]         n_held_right;
    logic signed [10:0] r_rh;
    logic signed [10:0] r_rv;
    logic signed [10:0] r_lh;
    logic signed [10:0] r_lv;
    logic signed [15:0] r_mx;
    logic signed [15:0] r_my;
    logic signed [15:0] r_mz;
    logic               r_pl;
    logic               r_pr;
    logic [15:0]        r_keys;
    logic [10:0]        c0;
    logic [10:0]        c1;
    logic [10:0]        c2;
    logic [10:0]        c3;

    function automatic logic [1:0] map_switch(input logic [1:0] raw, input logic [1:0] held);
        logic [1:0] pos;
        case (raw)
            2'd1:    pos = SW_UP;
            2'd2:    pos = SW_MID;
            2'd3:    pos = SW_DOWN;
            default: pos = held;
        endcase
        return pos;
    endfunction

    assign o_pop = i_q_status.nonempty && (!r_valid || o_out.ready);

    assign c0 = {i_frame[1][2:0], i_frame[0]};
    assign c1 = {i_frame[2][5:0], i_frame[1][7:3]};
    assign c2 = {i_frame[4][0], i_frame[3], i_frame[2][7:6]};
    assign c3 = {i_frame[5][3:0], i_frame[4][7:1]};

    assign n_held_left  = map_switch(i_frame[5][7:6], r_held_left);
    assign n_held_right = map_switch(i_frame[5][5:4], r_held_right);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_held_left  <= SW_DOWN;
            r_held_right <= SW_DOWN;
        end else if (o_pop) begin
            r_valid      <= 1'b1;
            r_held_left  <= n_held_left;
            r_held_right <= n_held_right;
        end else if (o_out.ready) begin
            r_valid      <= 1'b0;
        end
    end

    // Subtracting 1024 from an 11-bit raw value only flips its top bit.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rh   <= $signed({~c0[10], c0[9:0]});
            r_rv   <= $signed({~c1[10], c1[9:0]});
            r_lh   <= $signed({~c2[10], c2[9:0]});
            r_lv   <= $signed({~c3[10], c3[9:0]});
            r_mx   <= $signed({i_frame[7], i_frame[6]});
            r_my   <= $signed({i_frame[9], i_frame[8]});
            r_mz   <= $signed({i_frame[11], i_frame[10]});
            r_pl   <= (i_frame[12] != 8'd0);
            r_pr   <= (i_frame[13] != 8'd0);
            r_keys <= {i_frame[15], i_frame[14]};
        end
    end

    assign o_out.valid            = r_valid;
    assign o_out.right_horizontal = r_rh;
    assign o_out.right_vertical   = r_rv;
    assign o_out.left_horizontal  = r_lh;
    assign o_out.left_vertical    = r_lv;
    assign o_out.switch_left      = r_held_left;
    assign o_out.switch_right     = r_held_right;
    assign o_out.mouse_x          = r_mx;
    assign o_out.mouse_y          = r_my;
    assign o_out.mouse_z          = r_mz;
    assign o_out.press_left       = r_pl;
    assign o_out.press_right      = r_pr;
    assign o_out.key_mask         = r_keys;

endmodule

>>> hw/rtl/rc_frame_receiver_decoder.sv
// The decoder takes one UART event per clock cycle, a received byte or a
// line-idle mark, and answers each idle mark that follows at least FRAME_LEN
// bytes with one decoded remote control frame. Frames wait in a two-entry
// queue between the byte window and the decoder, so input stalls only when
// two complete frames are still held back by the result side. A frame is
// registered from the head of that queue onto the output; the result
// register lets a new frame be taken in the same cycle that the old one is.
// ----------------------------------------------------------------------------
// Remote control frame receiver and decoder
// Top level joining the front end, the frame queue and the decoder.
// ----------------------------------------------------------------------------
module rc_frame_receiver_decoder #(
    parameter int FRAME_LEN = 18
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rcfrd_in_if.sink    i_in,
    rcfrd_out_if.source o_out
);
    import rcfrd_pkg::*;

    t_queue_status q_status;
    t_frame        push_frame;
    t_frame        head_frame;
    logic          push;
    logic          pop;

    rcfrd_front #(
        .FRAME_LEN (FRAME_LEN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_status (q_status),
        .o_push     (push),
        .o_frame    (push_frame)
    );

    rcfrd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_frame  (push_frame),
        .i_pop    (pop),
        .o_frame  (head_frame),
        .o_status (q_status)
    );

    rcfrd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_frame    (head_frame),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

>>> hw/rtl/rcfrd_checker.sv
// ----------------------------------------------------------------------------
// Remote control frame decoder checker
// Port-level properties of the decoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "rc_frame_receiver_decoder_assert.svh"

module rcfrd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_switch_left,
    input logic [1:0]  i_switch_right,
    input logic [15:0] i_mouse_z,
    input logic [15:0] i_key_mask
);

    `RCFRD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_mouse_z) && $stable(i_key_mask))
    `RCFRD_ASSERT_NOW(a_left_pos, i_clk, i_rst_n, i_out_valid, i_switch_left != 2'd3)
    `RCFRD_ASSERT_NOW(a_right_pos, i_clk, i_rst_n, i_out_valid, i_switch_right != 2'd3)
    `RCFRD_ASSERT_NEXT(a_reset_idle, i_clk, 1'b1, !i_rst_n, !i_out_valid)

endmodule

bind rc_frame_receiver_decoder rcfrd_checker u_rcfrd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_switch_left  (o_out.switch_left),
    .i_switch_right (o_out.switch_right),
    .i_mouse_z      (o_out.mouse_z),
    .i_key_mask     (o_out.key_mask)
);
